// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers included by tcp_option_walker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: invariant violated");
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/tow_pkg.sv =====
// ----------------------------------------------------------------------------
// tow_pkg
// types and constants of the tcp option walker
// ----------------------------------------------------------------------------
package tow_pkg;

    localparam int BYTE_W = 8;
    localparam int SIZE_W = 16;

    localparam logic [BYTE_W-1:0] KIND_EOL    = 8'd0;
    localparam logic [BYTE_W-1:0] KIND_NOP    = 8'd1;
    localparam logic [BYTE_W-1:0] KIND_MSS    = 8'd2;
    localparam logic [BYTE_W-1:0] MSS_LENGTH  = 8'd4;
    localparam logic [BYTE_W-1:0] MIN_LENGTH  = 8'd2;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_EOL    = 3'd1,
        EV_NOP    = 3'd2,
        EV_MSS    = 3'd3,
        EV_OTHER  = 3'd4,
        EV_BROKEN = 3'd5,
        EV_LENERR = 3'd6
    } event_t;

    typedef enum logic [2:0] {
        PH_HALT   = 3'd0,
        PH_KIND   = 3'd1,
        PH_LEN    = 3'd2,
        PH_MSS_HI = 3'd3,
        PH_MSS_LO = 3'd4,
        PH_SKIP   = 3'd5
    } phase_t;

    typedef struct packed {
        event_t              event_kind;
        logic [SIZE_W-1:0]   segment_size;
        logic [BYTE_W-1:0]   option_length;
        logic                area_done;
    } result_t;

endpackage

// ===== rtl/core/tow_step.sv =====
// ----------------------------------------------------------------------------
// tow_step
// walk state registers and the per-byte next state and result logic
// ----------------------------------------------------------------------------
module tow_step #(
    parameter int AREA_BYTES = 40
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  logic [tow_pkg::BYTE_W-1:0]  option_byte,
    input  logic                        area_start,
    output logic                        res_valid,
    output tow_pkg::result_t            res
);

    localparam int PosW = $clog2(AREA_BYTES);
    localparam int SumW = tow_pkg::BYTE_W + 1;

    tow_pkg::phase_t             phase_reg, phase_next;
    logic [PosW-1:0]             pos_reg, pos_next;
    logic [PosW-1:0]             opt_start_reg, opt_start_next;
    logic [tow_pkg::BYTE_W-1:0]  skip_reg, skip_next;
    logic                        is_mss_reg, is_mss_next;
    logic [tow_pkg::BYTE_W-1:0]  size_hi_reg, size_hi_next;

    tow_pkg::phase_t             phase_cur;
    logic [PosW-1:0]             pos_cur;
    logic                        active;
    logic                        last_byte;
    logic [SumW-1:0]             opt_end;
    logic                        emit;
    logic                        stop;
    tow_pkg::event_t             ev;
    logic [tow_pkg::SIZE_W-1:0]  size_val;
    logic [tow_pkg::BYTE_W-1:0]  len_val;

    always_comb begin
        phase_cur      = area_start ? tow_pkg::PH_KIND : phase_reg;
        pos_cur        = area_start ? '0 : pos_reg;
        active         = area_start || (phase_reg != tow_pkg::PH_HALT);
        last_byte      = (pos_cur == PosW'(AREA_BYTES - 1));
        opt_end        = SumW'(opt_start_reg) + SumW'(option_byte);

        phase_next     = phase_cur;
        opt_start_next = opt_start_reg;
        skip_next      = skip_reg;
        is_mss_next    = is_mss_reg;
        size_hi_next   = size_hi_reg;
        emit           = 1'b0;
        stop           = 1'b0;
        ev             = tow_pkg::EV_NONE;
        size_val       = '0;
        len_val        = '0;

        unique case (phase_cur)
            tow_pkg::PH_KIND: begin
                opt_start_next = pos_cur;
                is_mss_next    = (option_byte == tow_pkg::KIND_MSS);
                if (option_byte == tow_pkg::KIND_EOL) begin
                    ev   = tow_pkg::EV_EOL;
                    emit = 1'b1;
                    stop = 1'b1;
                end else if (option_byte == tow_pkg::KIND_NOP) begin
                    ev   = tow_pkg::EV_NOP;
                    emit = 1'b1;
                end else if (last_byte) begin
                    // no room left for the length byte
                    ev   = tow_pkg::EV_LENERR;
                    emit = 1'b1;
                    stop = 1'b1;
                end else begin
                    phase_next = tow_pkg::PH_LEN;
                end
            end
            tow_pkg::PH_LEN: begin
                len_val = option_byte;
                if (option_byte < tow_pkg::MIN_LENGTH ||
                    opt_end > SumW'(AREA_BYTES)) begin
                    ev   = tow_pkg::EV_LENERR;
                    emit = 1'b1;
                    stop = 1'b1;
                end else if (is_mss_reg) begin
                    if (option_byte == tow_pkg::MSS_LENGTH) begin
                        phase_next = tow_pkg::PH_MSS_HI;
                        len_val    = '0;
                    end else begin
                        ev   = tow_pkg::EV_BROKEN;
                        emit = 1'b1;
                        stop = 1'b1;
                    end
                end else begin
                    ev        = tow_pkg::EV_OTHER;
                    emit      = 1'b1;
                    skip_next = option_byte - tow_pkg::MIN_LENGTH;
                    phase_next = (option_byte == tow_pkg::MIN_LENGTH) ?
                                 tow_pkg::PH_KIND : tow_pkg::PH_SKIP;
                end
            end
            tow_pkg::PH_MSS_HI: begin
                size_hi_next = option_byte;
                phase_next   = tow_pkg::PH_MSS_LO;
            end
            tow_pkg::PH_MSS_LO: begin
                ev         = tow_pkg::EV_MSS;
                emit       = 1'b1;
                size_val   = {size_hi_reg, option_byte};
                len_val    = tow_pkg::MSS_LENGTH;
                phase_next = tow_pkg::PH_KIND;
            end
            tow_pkg::PH_SKIP: begin
                skip_next = skip_reg - tow_pkg::BYTE_W'(1);
                if (skip_reg == tow_pkg::BYTE_W'(1)) begin
                    phase_next = tow_pkg::PH_KIND;
                end
            end
            default: begin
                phase_next = tow_pkg::PH_HALT;
            end
        endcase

        // the last byte of the area always closes the walk
        if (!stop && last_byte) begin
            stop = 1'b1;
            emit = 1'b1;
        end
        if (stop) begin
            phase_next = tow_pkg::PH_HALT;
        end
        pos_next = pos_cur + PosW'(1);

        res_valid         = active && emit;
        res.event_kind    = ev;
        res.segment_size  = size_val;
        res.option_length = len_val;
        res.area_done     = stop;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= tow_pkg::PH_HALT;
            pos_reg       <= '0;
            opt_start_reg <= '0;
            skip_reg      <= '0;
            is_mss_reg    <= 1'b0;
            size_hi_reg   <= '0;
        end else if (accept && active) begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            opt_start_reg <= opt_start_next;
            skip_reg      <= skip_next;
            is_mss_reg    <= is_mss_next;
            size_hi_reg   <= size_hi_next;
        end
    end

endmodule

// ===== rtl/core/tow_out_reg.sv =====
// ----------------------------------------------------------------------------
// tow_out_reg
// result register of the walker, refilled in the cycle it is drained
// ----------------------------------------------------------------------------
module tow_out_reg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  logic                          load_valid,
    input  tow_pkg::result_t              load_data,
    output logic                          free,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_event_kind,
    output logic [tow_pkg::SIZE_W-1:0]    m_segment_size,
    output logic [tow_pkg::BYTE_W-1:0]    m_option_length,
    output logic                          m_area_done
);

    logic             valid_reg;
    tow_pkg::result_t data_reg;

    assign free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load && load_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (free && load && load_valid) begin
            data_reg <= load_data;
        end
    end

    assign m_valid         = valid_reg;
    assign m_event_kind    = data_reg.event_kind;
    assign m_segment_size  = data_reg.segment_size;
    assign m_option_length = data_reg.option_length;
    assign m_area_done     = data_reg.area_done;

endmodule

// ===== rtl/core/tcp_option_walker.sv =====
// ----------------------------------------------------------------------------
// tcp_option_walker
// byte-serial walker over a tcp option area with registered results
// ----------------------------------------------------------------------------
// takes one option byte per transaction, s_area_start marking the first byte
// of an area of AREA_BYTES bytes. it reports end-of-list, each no-op, mss
// with its big-endian value, and other options with their length byte; a
// broken mss length, a length below 2 or an option running past the area is
// flagged and ends the walk. after the walk ends, bytes are dropped without a
// result until the next area start; the last byte of an area, if the walk is
// still running, yields a result with m_area_done set. a byte is taken every
// cycle while s_ready is high: the walk takes one short step per byte and each
// result sits in a single output register: it shows in the cycle after its byte
// is taken; s_ready only drops while that register holds an untaken result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcp_option_walker #(
    parameter int AREA_BYTES = 40
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // option bytes
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tow_pkg::BYTE_W-1:0]    s_option_byte,
    input  logic                          s_area_start,
    // walk events
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_event_kind,
    output logic [tow_pkg::SIZE_W-1:0]    m_segment_size,
    output logic [tow_pkg::BYTE_W-1:0]    m_option_length,
    output logic                          m_area_done
);

    logic             accept;
    logic             res_valid;
    tow_pkg::result_t res;

    // a byte moves in whenever the output register is empty or drains now
    assign accept = s_valid && s_ready;

    // walk state and per-byte decision
    tow_step #(
        .AREA_BYTES (AREA_BYTES)
    ) u_step (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .option_byte (s_option_byte),
        .area_start  (s_area_start),
        .res_valid   (res_valid),
        .res         (res)
    );

    // result register toward the consumer
    tow_out_reg u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (accept),
        .load_valid      (res_valid),
        .load_data       (res),
        .free            (s_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_kind    (m_event_kind),
        .m_segment_size  (m_segment_size),
        .m_option_length (m_option_length),
        .m_area_done     (m_area_done)
    );

    // an empty output register never holds back the input side
    `ASSERT_IMPLY(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)
    // end-of-list, broken mss and length errors always close the walk
    `ASSERT_IMPLY(a_fatal_closes, aclk, aresetn,
        m_valid && (m_event_kind == tow_pkg::EV_EOL ||
                    m_event_kind == tow_pkg::EV_BROKEN ||
                    m_event_kind == tow_pkg::EV_LENERR),
        m_area_done)
    // only an mss result carries a segment size, and it reports length four
    `ASSERT_ALWAYS(a_mss_fields, aclk, aresetn,
        !m_valid || (m_event_kind == tow_pkg::EV_MSS ?
                     m_option_length == tow_pkg::MSS_LENGTH : m_segment_size == '0))

endmodule

// ===== dv/tcp_option_walker_checker.sv =====
// ----------------------------------------------------------------------------
// tcp_option_walker_checker
// watches both channels of the option walker, predicts its walk events and
// compares every accepted event field by field with the oldest prediction
// ----------------------------------------------------------------------------
module tcp_option_walker_checker #(
    parameter int AREA_BYTES = 40
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [tow_pkg::BYTE_W-1:0]    s_option_byte,
    input  logic                          s_area_start,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [2:0]                    m_event_kind,
    input  logic [tow_pkg::SIZE_W-1:0]    m_segment_size,
    input  logic [tow_pkg::BYTE_W-1:0]    m_option_length,
    input  logic                          m_area_done,
    output int                            fail_count,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // walk state of the predictor
    tow_pkg::phase_t   walk_phase;
    logic [5:0]        next_pos;
    logic [5:0]        kind_pos;
    logic [7:0]        skip_left;
    logic [7:0]        cur_kind;
    logic [7:0]        size_hi;

    tow_pkg::result_t  expected_events[$];
    int                mismatch_count;

    task automatic clear_walk();
        walk_phase = tow_pkg::PH_HALT;
        next_pos   = '0;
        kind_pos   = '0;
        skip_left  = '0;
        cur_kind   = '0;
        size_hi    = '0;
    endtask

    // one option byte through the walk; emit tells whether an event comes out
    task automatic walk_byte(input logic [7:0] b, input logic first,
                             output bit emit, output tow_pkg::result_t ev);
        int  pos;
        bit  stop;
        emit = 1'b0;
        stop = 1'b0;
        ev   = '0;
        ev.event_kind = tow_pkg::EV_NONE;
        if (first) begin
            walk_phase = tow_pkg::PH_KIND;
            next_pos   = '0;
        end else if (walk_phase == tow_pkg::PH_HALT || walk_phase > tow_pkg::PH_SKIP) begin
            walk_phase = tow_pkg::PH_HALT;
            return;
        end
        pos = int'(next_pos);

        case (walk_phase)
            tow_pkg::PH_KIND: begin
                kind_pos = pos[5:0];
                cur_kind = b;
                if (b == tow_pkg::KIND_EOL) begin
                    ev.event_kind = tow_pkg::EV_EOL;
                    emit = 1'b1;
                    stop = 1'b1;
                end else if (b == tow_pkg::KIND_NOP) begin
                    ev.event_kind = tow_pkg::EV_NOP;
                    emit = 1'b1;
                end else if (pos + 1 >= AREA_BYTES) begin
                    ev.event_kind = tow_pkg::EV_LENERR;
                    emit = 1'b1;
                    stop = 1'b1;
                end else begin
                    walk_phase = tow_pkg::PH_LEN;
                end
            end
            tow_pkg::PH_LEN: begin
                ev.option_length = b;
                if (b < tow_pkg::MIN_LENGTH ||
                    int'(kind_pos) + int'(b) > AREA_BYTES) begin
                    ev.event_kind = tow_pkg::EV_LENERR;
                    emit = 1'b1;
                    stop = 1'b1;
                end else if (cur_kind == tow_pkg::KIND_MSS) begin
                    if (b == tow_pkg::MSS_LENGTH) begin
                        walk_phase = tow_pkg::PH_MSS_HI;
                        ev.option_length = '0;
                    end else begin
                        ev.event_kind = tow_pkg::EV_BROKEN;
                        emit = 1'b1;
                        stop = 1'b1;
                    end
                end else begin
                    ev.event_kind = tow_pkg::EV_OTHER;
                    emit = 1'b1;
                    skip_left = b - tow_pkg::MIN_LENGTH;
                    walk_phase = (skip_left != 0) ? tow_pkg::PH_SKIP : tow_pkg::PH_KIND;
                end
            end
            tow_pkg::PH_MSS_HI: begin
                size_hi = b;
                walk_phase = tow_pkg::PH_MSS_LO;
            end
            tow_pkg::PH_MSS_LO: begin
                ev.event_kind = tow_pkg::EV_MSS;
                ev.segment_size = {size_hi, b};
                ev.option_length = tow_pkg::MSS_LENGTH;
                emit = 1'b1;
                walk_phase = tow_pkg::PH_KIND;
            end
            default: begin
                if (skip_left != 0)
                    skip_left = skip_left - 8'd1;
                if (skip_left == 0)
                    walk_phase = tow_pkg::PH_KIND;
            end
        endcase

        // the last byte of the area always closes the walk
        if (!stop && pos + 1 >= AREA_BYTES) begin
            stop = 1'b1;
            emit = 1'b1;
        end
        if (stop)
            walk_phase = tow_pkg::PH_HALT;
        next_pos = 6'(pos + 1);
        ev.area_done = stop;
    endtask

    always @(posedge aclk) begin : monitor
        bit               emit;
        tow_pkg::result_t want;
        tow_pkg::result_t got;
        if (!aresetn) begin
            clear_walk();
            expected_events.delete();
        end else begin
            if (s_valid && s_ready) begin
                walk_byte(s_option_byte, s_area_start, emit, want);
                if (emit)
                    expected_events.push_back(want);
            end
            if (m_valid && m_ready) begin
                got.event_kind    = tow_pkg::event_t'(m_event_kind);
                got.segment_size  = m_segment_size;
                got.option_length = m_option_length;
                got.area_done     = m_area_done;
                if (expected_events.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected event: kind %0d size %h len %0d done %b",
                                 m_event_kind, m_segment_size, m_option_length,
                                 m_area_done);
                    mismatch_count++;
                end else begin
                    want = expected_events.pop_front();
                    if (got.event_kind !== want.event_kind ||
                        got.segment_size !== want.segment_size ||
                        got.option_length !== want.option_length ||
                        got.area_done !== want.area_done) begin
                        if (mismatch_count < 10)
                            $display(
                                "mismatch kind/size/len/done: exp %0d/%h/%0d/%b got %0d/%h/%0d/%b",
                                want.event_kind, want.segment_size,
                                want.option_length, want.area_done,
                                m_event_kind, m_segment_size, m_option_length,
                                m_area_done);
                        mismatch_count++;
                    end
                end
            end
        end
        pending    <= expected_events.size();
        fail_count <= mismatch_count;
    end

endmodule

// ===== dv/tcp_option_walker_test.sv =====
// ----------------------------------------------------------------------------
// tcp_option_walker_test
// stimulus and verdict for the tcp option walker
// ----------------------------------------------------------------------------
// drives option areas into the walker one byte per transaction: a short
// directed run over the corner cases first, then random areas that are mostly
// well formed (nop, mss, other options, end-of-list, broken lengths, cut-off
// areas) with some raw noise. both sides idle at random per transaction.
// the checker beside the block predicts and compares; this module gives the
// verdict once every predicted event has arrived.
// ----------------------------------------------------------------------------
module tcp_option_walker_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AREA_BYTES   = 40;
    localparam int RANDOM_ITEMS = 1150;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [tow_pkg::BYTE_W-1:0]    s_option_byte = '0;
    logic                          s_area_start = 1'b0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [2:0]                    m_event_kind;
    logic [tow_pkg::SIZE_W-1:0]    m_segment_size;
    logic [tow_pkg::BYTE_W-1:0]    m_option_length;
    logic                          m_area_done;

    int                   fail_count;
    int                   pending;

    // generator state for the area being built
    int                   items_sent;
    int                   area_left;
    int                   cut_left;
    bit                   area_first;
    bit                   driver_free;
    bit                   sink_free;

    tcp_option_walker #(
        .AREA_BYTES(AREA_BYTES)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_option_byte  (s_option_byte),
        .s_area_start   (s_area_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_segment_size (m_segment_size),
        .m_option_length(m_option_length),
        .m_area_done    (m_area_done)
    );

    tcp_option_walker_checker #(
        .AREA_BYTES(AREA_BYTES)
    ) i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_option_byte  (s_option_byte),
        .s_area_start   (s_area_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_segment_size (m_segment_size),
        .m_option_length(m_option_length),
        .m_area_done    (m_area_done),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // one byte transaction; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic first);
        int gap;
        gap = driver_free ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_option_byte <= b;
        s_area_start  <= first;
        // hold the payload until the block takes it
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        @(negedge aclk);
    endtask

    // next byte of the area; dropped once the area has been cut short
    task automatic put_byte(input logic [7:0] b);
        if (area_left <= cut_left)
            return;
        send_byte(b, area_first);
        area_first = 1'b0;
        area_left--;
    endtask

    task automatic send_area();
        int  sel;
        int  r;
        int  len;
        int  top_len;
        bit  may_end;
        bit  done;
        area_left   = AREA_BYTES;
        area_first  = 1'b1;
        done        = 1'b0;
        driver_free = ($urandom_range(0, 3) == 0);
        // now and then a new area start arrives in the middle of a walk
        cut_left = ($urandom_range(0, 7) == 0) ? $urandom_range(1, AREA_BYTES - 1) : 0;

        // raw noise: random bytes with a sparse sprinkling of area starts
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12))
                send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
            return;
        end

        // areas without terminators run on to the last byte
        may_end = ($urandom_range(0, 2) != 0);
        while (area_left > cut_left && !done) begin
            sel = may_end ? $urandom_range(0, 99) : $urandom_range(0, 64);
            r   = area_left;
            if (sel < 15) begin
                put_byte(tow_pkg::KIND_NOP);
            end else if (sel < 30) begin
                // mss; near the end of the area this turns into an overrun
                put_byte(tow_pkg::KIND_MSS);
                put_byte(tow_pkg::MSS_LENGTH);
                put_byte(8'($urandom_range(0, 255)));
                put_byte(8'($urandom_range(0, 255)));
            end else if (sel < 65) begin
                // other option, kind alone on the last byte is a length error
                put_byte(8'($urandom_range(3, 255)));
                if (r >= 2) begin
                    top_len = (r < 12) ? r : 12;
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(2, r)
                                                      : $urandom_range(2, top_len);
                    put_byte(8'(len));
                    repeat (len - 2) put_byte(8'($urandom_range(0, 255)));
                end
            end else if (sel < 72) begin
                put_byte(tow_pkg::KIND_EOL);
                done = 1'b1;
            end else if (sel < 80) begin
                // mss with a wrong length byte
                put_byte(tow_pkg::KIND_MSS);
                len = $urandom_range(0, 255);
                if (len == tow_pkg::MSS_LENGTH)
                    len++;
                put_byte(8'(len));
                done = 1'b1;
            end else if (sel < 87) begin
                // length below the minimum
                put_byte(8'($urandom_range(2, 255)));
                put_byte(8'($urandom_range(0, 1)));
                done = 1'b1;
            end else begin
                // length reaching past the area
                put_byte(8'($urandom_range(3, 255)));
                put_byte(8'($urandom_range(r + 1, 255)));
                done = 1'b1;
            end
        end
        // bytes after the walk has ended are dropped by the block
        if (done)
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // receiver: random stall before each transaction, stretches without stalls
    initial begin : sink
        int stall;
        int taken;
        taken = 0;
        sink_free = 1'b0;
        wait (aresetn == 1'b1);
        @(negedge aclk);
        forever begin
            stall = sink_free ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
            if (taken % 50 == 0)
                sink_free = ($urandom_range(0, 3) == 0);
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        items_sent  = 0;
        driver_free = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // byte while halted, no event
        send_byte(8'hAA, 1'b0);
        // nop opening an area
        send_byte(tow_pkg::KIND_NOP, 1'b1);
        // mss with the largest value
        send_byte(tow_pkg::KIND_MSS, 1'b0);
        send_byte(tow_pkg::MSS_LENGTH, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        // other option of minimum length, then one with a skipped byte
        send_byte(8'h80, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h55, 1'b0);
        // broken mss ends the walk, next byte is dropped
        send_byte(tow_pkg::KIND_MSS, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h00, 1'b0);
        // short length on an other option
        send_byte(8'h05, 1'b1);
        send_byte(8'h01, 1'b0);
        // mss whose length runs past the area
        send_byte(tow_pkg::KIND_MSS, 1'b1);
        send_byte(8'hFF, 1'b0);
        // mss with zero length
        send_byte(tow_pkg::KIND_MSS, 1'b1);
        send_byte(8'h00, 1'b0);
        // option abandoned by a restart, then an mss of zero
        send_byte(8'h09, 1'b1);
        send_byte(tow_pkg::KIND_MSS, 1'b1);
        send_byte(tow_pkg::MSS_LENGTH, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        // restart straight into end-of-list
        send_byte(tow_pkg::KIND_EOL, 1'b1);

        while (items_sent < RANDOM_ITEMS)
            send_area();

        s_valid <= 1'b0;
        // drain the outstanding events, then give the block time for strays
        while (pending != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial begin : watchdog
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
